>>> rtl/pmu_pkg.sv
// ----------------------------------------------------------------------------
// pmu_pkg: shared types and constants of the particle motion block
// Command codes, register indexes, the sequencer states, the command queue
// entry, the particle table entry and the result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pmu_pkg;

   localparam logic [31:0] RISE = 32'h0064_0000;  // 100.0 in Q16.16
   localparam logic [30:0] AGE_MAX = 31'h7FFF_FFFF;

   typedef enum logic [1:0] {
      CMD_LOAD   = 2'd0,
      CMD_SPREAD = 2'd1,
      CMD_DROP   = 2'd2,
      CMD_DIAG   = 2'd3
   } cmd_code_type;

   typedef enum logic [2:0] {
      CSR_PIVOT_X  = 3'd0,
      CSR_PIVOT_Y  = 3'd1,
      CSR_PIVOT_Z  = 3'd2,
      CSR_LOOP_EN  = 3'd3,
      CSR_IN_USE   = 3'd4
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FETCH,
      ST_SCALE,
      ST_SQUARE,
      ST_ROOT,
      ST_DIVIDE,
      ST_APPLY,
      ST_MOVE,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic signed [31:0] pivot_x;
      logic signed [31:0] pivot_y;
      logic signed [31:0] pivot_z;
      logic               loop_enable;
      logic [6:0]         in_use;
   } cfg_type;

   typedef struct packed {
      cmd_code_type       op;
      logic [5:0]         slot;
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [31:0] start_z;
      logic signed [31:0] speed;
      logic [30:0]        limit;
      logic [30:0]        dt;
      logic signed [31:0] box_min_x;
      logic signed [31:0] box_min_z;
      logic signed [31:0] box_max_x;
      logic signed [31:0] box_max_z;
   } cmd_type;

   typedef struct packed {
      logic signed [31:0] cur_x;
      logic signed [31:0] cur_y;
      logic signed [31:0] cur_z;
      logic signed [31:0] org_x;
      logic signed [31:0] org_y;
      logic signed [31:0] org_z;
      logic signed [31:0] speed;
      logic [30:0]        age;
      logic [30:0]        limit;
   } ent_type;

   typedef struct packed {
      logic [5:0]         index;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [30:0]        life;
      logic               last;
   } rsp_type;

endpackage

>>> rtl/pmu_fifo.sv
// ----------------------------------------------------------------------------
// pmu_fifo: two-entry queue
// Decouples producer and consumer; full and empty decode a registered count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pmu_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       count_ff;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign rdata   = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) wr_ptr_ff <= !wr_ptr_ff;
         if (do_pop) rd_ptr_ff <= !rd_ptr_ff;
         if (do_push && !do_pop) count_ff <= count_ff + 2'd1;
         else if (do_pop && !do_push) count_ff <= count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= wdata;
   end

endmodule

>>> rtl/pmu_front.sv
// ----------------------------------------------------------------------------
// pmu_front: command intake
// Decodes incoming items, drops loads aimed past the table and queues the
// rest for the engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pmu_front import pmu_pkg::*; #(
   parameter int MAX_PARTICLES = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [1:0]         req_command,
   input  logic [5:0]         req_slot,
   input  logic signed [31:0] req_start_x,
   input  logic signed [31:0] req_start_y,
   input  logic signed [31:0] req_start_z,
   input  logic signed [31:0] req_move_speed,
   input  logic [30:0]        req_life_limit,
   input  logic [30:0]        req_time_step,
   input  logic signed [31:0] req_box_min_x,
   input  logic signed [31:0] req_box_min_z,
   input  logic signed [31:0] req_box_max_x,
   input  logic signed [31:0] req_box_max_z,
   input  logic               req_push,
   output logic               req_full,
   output cmd_type            cmd,
   output logic               cmd_valid,
   input  logic               cmd_pop
);

   cmd_type                    cmd_in;
   logic                       keep;
   logic                       cmd_empty;
   logic [$bits(cmd_type)-1:0] cmd_raw;

   always_comb begin
      cmd_in.op        = cmd_code_type'(req_command);
      cmd_in.slot      = req_slot;
      cmd_in.start_x   = req_start_x;
      cmd_in.start_y   = req_start_y;
      cmd_in.start_z   = req_start_z;
      cmd_in.speed     = req_move_speed;
      cmd_in.limit     = req_life_limit;
      cmd_in.dt        = req_time_step;
      cmd_in.box_min_x = req_box_min_x;
      cmd_in.box_min_z = req_box_min_z;
      cmd_in.box_max_x = req_box_max_x;
      cmd_in.box_max_z = req_box_max_z;
      keep = !(cmd_in.op == CMD_LOAD && 32'(req_slot) >= MAX_PARTICLES);
   end

   pmu_fifo #(.WIDTH($bits(cmd_type))) u_cmd_queue (
      .clock (clock),
      .reset (reset),
      .push  (req_push && keep),
      .wdata (cmd_in),
      .full  (req_full),
      .pop   (cmd_pop),
      .rdata (cmd_raw),
      .empty (cmd_empty)
   );

   assign cmd       = cmd_raw;
   assign cmd_valid = !cmd_empty;

endmodule

>>> rtl/pmu_isqrt.sv
// ----------------------------------------------------------------------------
// pmu_isqrt: integer square root
// Digit-by-digit floor square root of a 64-bit value, one root bit a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pmu_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        done,
   output logic [31:0] root
);

   logic        busy_ff;
   logic        done_ff;
   logic [4:0]  cnt_ff;
   logic [63:0] x_ff;
   logic [33:0] rem_ff;
   logic [31:0] root_ff;
   logic [33:0] rem_sh;
   logic [33:0] trial;
   logic        ge;

   assign rem_sh = {rem_ff[31:0], x_ff[63:62]};
   assign trial  = {root_ff, 2'b01};
   assign ge     = (rem_sh >= trial);
   assign done   = done_ff;
   assign root   = root_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 5'd0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff    <= radicand;
         rem_ff  <= 34'd0;
         root_ff <= 32'd0;
      end else if (busy_ff) begin
         x_ff    <= {x_ff[61:0], 2'b00};
         rem_ff  <= ge ? (rem_sh - trial) : rem_sh;
         root_ff <= {root_ff[30:0], ge};
      end
   end

endmodule

>>> rtl/pmu_div.sv
// ----------------------------------------------------------------------------
// pmu_div: unit-vector divider
// Restoring divide of (mag << 16) by the norm, one quotient bit a cycle.
// The quotient never exceeds 17 bits since mag <= norm.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pmu_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [30:0] num,
   input  logic [31:0] den,
   output logic        done,
   output logic [16:0] quot
);

   logic        busy_ff;
   logic        done_ff;
   logic [4:0]  cnt_ff;
   logic [31:0] rem_ff;
   logic [16:0] low_ff;
   logic [16:0] q_ff;
   logic [31:0] den_ff;
   logic [32:0] rs;
   logic [32:0] diff;
   logic        ge;

   assign rs   = {rem_ff, low_ff[16]};
   assign diff = rs - {1'b0, den_ff};
   assign ge   = (rs >= {1'b0, den_ff});
   assign done = done_ff;
   assign quot = q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 5'd0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd16) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= {2'b00, num[30:1]};
         low_ff <= {num[0], 16'h0000};
         q_ff   <= 17'd0;
         den_ff <= den;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[31:0] : rs[31:0];
         low_ff <= {low_ff[15:0], 1'b0};
         q_ff   <= {q_ff[15:0], ge};
      end
   end

endmodule

>>> rtl/pmu_engine.sv
// ----------------------------------------------------------------------------
// pmu_engine: particle table and update sequencer
// Executes loads and ticks: walks the table one particle at a time through a
// shared multiplier, the root and divide units, and queues the results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pmu_engine import pmu_pkg::*; #(
   parameter int MAX_PARTICLES = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  cmd_type cmd,
   input  logic    cmd_valid,
   output logic    cmd_pop,
   output rsp_type rsp,
   output logic    rsp_empty,
   input  logic    rsp_pop
);

   localparam int AW  = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
   localparam int CAP = (MAX_PARTICLES < 64) ? MAX_PARTICLES : 64;

   // table
   ent_type          mem [MAX_PARTICLES];
   ent_type          rd_ff;
   ent_type          wr_data;
   logic [AW-1:0]    wr_addr;
   logic             mem_we;

   // control
   state_type        state_ff, state_in;
   logic [2:0]       step_ff;
   logic [AW-1:0]    idx_ff;
   logic [AW-1:0]    last_idx_ff;
   cmd_type          tick_ff;
   logic [6:0]       n_walk;
   logic             is_last;

   // datapath
   logic [31:0]        mul_a, mul_b;
   logic [63:0]        mul_p, mul_ff;
   logic [46:0]        smag_ff;
   logic [30:0]        m_ff [3];
   logic               dneg_ff [3];
   logic               still_ff;
   logic [63:0]        sum_ff;
   logic [31:0]        pl_ff;
   logic signed [31:0] pos_ff [3];
   logic               sneg;
   logic [31:0]        spd_mag;

   logic signed [31:0] cur [3];
   logic signed [31:0] piv [3];
   logic [32:0]        dmag [3];
   logic               dsgn [3];
   logic [30:0]        m_new [3];
   logic               sh1, sh2, still_new;

   logic [31:0]        mv_lo;
   logic signed [31:0] mv_x, mv_y, mv_y_fin;
   logic               mv_out;

   logic [1:0]         ap_comp;
   logic [31:0]        ap_dm;

   logic [31:0]        age_sum;
   logic [30:0]        age_new;
   logic               respawn;
   ent_type            commit_ent;
   rsp_type            rsp_in;

   logic               sqrt_start, sqrt_done;
   logic [63:0]        radicand;
   logic [31:0]        sqrt_root;
   logic               div_start;
   logic [2:0]         div_done;
   logic [16:0]        quot [3];

   logic               rsp_push, rsp_full;
   logic [$bits(rsp_type)-1:0] rsp_raw;

   always_ff @(posedge clock) begin
      if (mem_we) mem[wr_addr] <= wr_data;
      rd_ff <= mem[idx_ff];
   end

   assign mul_p = mul_a * mul_b;
   always_ff @(posedge clock) mul_ff <= mul_p;

   assign sneg    = rd_ff.speed[31];
   assign spd_mag = sneg ? 32'(-rd_ff.speed) : 32'(rd_ff.speed);
   assign n_walk  = (cfg.in_use > 7'(CAP)) ? 7'(CAP) : cfg.in_use;
   assign is_last = (idx_ff == last_idx_ff);

   // spread direction
   always_comb begin
      logic [32:0] diff;
      cur[0] = rd_ff.cur_x;
      cur[1] = rd_ff.cur_y;
      cur[2] = rd_ff.cur_z;
      piv[0] = cfg.pivot_x;
      piv[1] = cfg.pivot_y;
      piv[2] = cfg.pivot_z;
      for (int k = 0; k < 3; k++) begin
         diff    = {cur[k][31], cur[k]} - {piv[k][31], piv[k]};
         dsgn[k] = diff[32];
         dmag[k] = diff[32] ? (33'd0 - diff) : diff;
      end
      sh2       = dmag[0][32] | dmag[1][32] | dmag[2][32];
      sh1       = dmag[0][31] | dmag[1][31] | dmag[2][31];
      still_new = (dmag[0] == 33'd0) && (dmag[1] == 33'd0) && (dmag[2] == 33'd0);
      for (int k = 0; k < 3; k++) begin
         if (sh2) m_new[k] = dmag[k][32:2];
         else if (sh1) m_new[k] = dmag[k][31:1];
         else m_new[k] = dmag[k][30:0];
      end
   end

   // drop and diagonal moves
   always_comb begin
      mv_lo  = mul_ff[47:16];
      mv_y   = sneg ? (pos_ff[1] + mv_lo) : (pos_ff[1] - mv_lo);
      mv_x   = sneg ? (pos_ff[0] + mv_lo) : (pos_ff[0] - mv_lo);
      mv_out = ($signed(mv_x) < $signed(tick_ff.box_min_x)) ||
               ($signed(mv_x) > $signed(tick_ff.box_max_x)) ||
               ($signed(pos_ff[2]) < $signed(tick_ff.box_min_z)) ||
               ($signed(pos_ff[2]) > $signed(tick_ff.box_max_z));
      mv_y_fin = (tick_ff.op == CMD_DIAG && mv_out) ? (mv_y + RISE) : mv_y;
   end

   assign ap_comp = step_ff[2:1] - 2'd1;
   assign ap_dm   = pl_ff + {mul_ff[15:0], 16'h0000};

   // commit
   always_comb begin
      age_sum = {1'b0, rd_ff.age} + {1'b0, tick_ff.dt};
      age_new = age_sum[31] ? AGE_MAX : age_sum[30:0];
      respawn = cfg.loop_enable && (age_new >= rd_ff.limit);
      commit_ent       = rd_ff;
      commit_ent.cur_x = respawn ? rd_ff.org_x : pos_ff[0];
      commit_ent.cur_y = respawn ? rd_ff.org_y : pos_ff[1];
      commit_ent.cur_z = respawn ? rd_ff.org_z : pos_ff[2];
      commit_ent.age   = respawn ? 31'd0 : age_new;
      rsp_in.index = 6'(idx_ff);
      rsp_in.pos_x = commit_ent.cur_x;
      rsp_in.pos_y = commit_ent.cur_y;
      rsp_in.pos_z = commit_ent.cur_z;
      rsp_in.life  = commit_ent.age;
      rsp_in.last  = is_last;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && cmd.op != CMD_LOAD && n_walk != 7'd0) state_in = ST_FETCH;
         end
         ST_FETCH:  state_in = ST_SCALE;
         ST_SCALE:  state_in = (tick_ff.op == CMD_SPREAD) ? ST_SQUARE : ST_MOVE;
         ST_SQUARE: begin
            if (step_ff == 3'd3) state_in = still_ff ? ST_COMMIT : ST_ROOT;
         end
         ST_ROOT:   if (sqrt_done) state_in = ST_DIVIDE;
         ST_DIVIDE: if (div_done[0]) state_in = ST_APPLY;
         ST_APPLY:  if (step_ff == 3'd6) state_in = ST_COMMIT;
         ST_MOVE:   state_in = ST_COMMIT;
         ST_COMMIT: if (!rsp_full) state_in = is_last ? ST_IDLE : ST_FETCH;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      mul_a      = 32'd0;
      mul_b      = 32'd0;
      mem_we     = 1'b0;
      wr_addr    = idx_ff;
      wr_data    = commit_ent;
      cmd_pop    = 1'b0;
      rsp_push   = 1'b0;
      sqrt_start = 1'b0;
      radicand   = sum_ff + mul_ff;
      div_start  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               if (cmd.op == CMD_LOAD) begin
                  mem_we        = 1'b1;
                  wr_addr       = AW'(cmd.slot);
                  wr_data.cur_x = cmd.start_x;
                  wr_data.cur_y = cmd.start_y;
                  wr_data.cur_z = cmd.start_z;
                  wr_data.org_x = cmd.start_x;
                  wr_data.org_y = cmd.start_y;
                  wr_data.org_z = cmd.start_z;
                  wr_data.speed = cmd.speed;
                  wr_data.age   = 31'd0;
                  wr_data.limit = cmd.limit;
               end
            end
         end
         ST_SCALE: begin
            mul_a = spd_mag;
            mul_b = {1'b0, tick_ff.dt};
         end
         ST_SQUARE: begin
            if (step_ff != 3'd3) begin
               mul_a = {1'b0, m_ff[step_ff[1:0]]};
               mul_b = {1'b0, m_ff[step_ff[1:0]]};
            end else begin
               sqrt_start = !still_ff;
            end
         end
         ST_ROOT: div_start = sqrt_done;
         ST_APPLY: begin
            if (step_ff != 3'd6) begin
               mul_a = {15'd0, quot[step_ff[2:1]]};
               mul_b = step_ff[0] ? {17'd0, smag_ff[46:32]} : smag_ff[31:0];
            end
         end
         ST_COMMIT: begin
            if (!rsp_full) begin
               mem_we   = 1'b1;
               rsp_push = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= 3'd0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= (state_in != state_ff) ? 3'd0 : step_ff + 3'd1;
         if (state_ff == ST_IDLE) idx_ff <= '0;
         else if (rsp_push) idx_ff <= idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && cmd.op != CMD_LOAD) begin
               tick_ff     <= cmd;
               last_idx_ff <= AW'(32'(n_walk) - 32'd1);
            end
         end
         ST_SCALE: begin
            still_ff <= still_new;
            for (int k = 0; k < 3; k++) begin
               pos_ff[k]  <= cur[k];
               m_ff[k]    <= m_new[k];
               dneg_ff[k] <= dsgn[k];
            end
         end
         ST_SQUARE: begin
            if (step_ff == 3'd0) smag_ff <= mul_ff[62:16];
            else if (step_ff == 3'd1) sum_ff <= mul_ff;
            else if (step_ff == 3'd2) sum_ff <= sum_ff + mul_ff;
         end
         ST_APPLY: begin
            if (step_ff != 3'd0) begin
               if (step_ff[0]) begin
                  pl_ff <= mul_ff[47:16];
               end else begin
                  for (int k = 0; k < 3; k++) begin
                     if (2'(k) == ap_comp)
                        pos_ff[k] <= (dneg_ff[k] ^ sneg) ? (pos_ff[k] - ap_dm)
                                                          : (pos_ff[k] + ap_dm);
                  end
               end
            end
         end
         ST_MOVE: begin
            pos_ff[1] <= mv_y_fin;
            if (tick_ff.op == CMD_DIAG) pos_ff[0] <= mv_x;
         end
         default: ;
      endcase
   end

   pmu_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (radicand),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   for (genvar g = 0; g < 3; g++) begin : g_div
      pmu_div u_div (
         .clock (clock),
         .reset (reset),
         .start (div_start),
         .num   (m_ff[g]),
         .den   (sqrt_root),
         .done  (div_done[g]),
         .quot  (quot[g])
      );
   end

   pmu_fifo #(.WIDTH($bits(rsp_type))) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (rsp_in),
      .full  (rsp_full),
      .pop   (rsp_pop),
      .rdata (rsp_raw),
      .empty (rsp_empty)
   );

   assign rsp = rsp_raw;

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full) else $error("result pushed into full queue");
   a_write_state: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_IDLE || state_ff == ST_COMMIT))
      else $error("table written outside load or commit");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_push && rsp_in.last) |=> (state_ff == ST_IDLE))
      else $error("walk continued past last particle");
   a_norm_nonzero: assert property (@(posedge clock) disable iff (reset)
      div_start |-> (sqrt_root != 32'd0)) else $error("divide by zero norm");
`endif

endmodule

>>> rtl/particle_motion_update.sv
// Load: written to the table when the engine is idle; no result.
// Drop and diagonal ticks: each particle is read, scaled, moved and committed.
// Spread tick: each particle runs the 32-step square root and the 17-step divide
// (skipped for a particle on the pivot); particles are handled one at a time.
// Reset clears control and registers; the particle table is undefined until loaded.
// ----------------------------------------------------------------------------
// particle_motion_update: particle table with Euler-step motion
// Front intake queue, update engine with table, root and divide units, and a
// result queue. Configuration registers live here.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module particle_motion_update import pmu_pkg::*; #(
   parameter int MAX_PARTICLES = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [1:0]         req_command,
   input  logic [5:0]         req_slot,
   input  logic signed [31:0] req_start_x,
   input  logic signed [31:0] req_start_y,
   input  logic signed [31:0] req_start_z,
   input  logic signed [31:0] req_move_speed,
   input  logic [30:0]        req_life_limit,
   input  logic [30:0]        req_time_step,
   input  logic signed [31:0] req_box_min_x,
   input  logic signed [31:0] req_box_min_z,
   input  logic signed [31:0] req_box_max_x,
   input  logic signed [31:0] req_box_max_z,
   input  logic               push,
   output logic               full,
   output logic [5:0]         rsp_particle_index,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic signed [31:0] rsp_pos_z,
   output logic [30:0]        rsp_life_elapsed,
   output logic               rsp_last,
   output logic               empty,
   input  logic               pop,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_pop;
   rsp_type rsp;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_PIVOT_X: cfg_in.pivot_x     = csr_wdata;
            CSR_PIVOT_Y: cfg_in.pivot_y     = csr_wdata;
            CSR_PIVOT_Z: cfg_in.pivot_z     = csr_wdata;
            CSR_LOOP_EN: cfg_in.loop_enable = csr_wdata[0];
            CSR_IN_USE:  cfg_in.in_use      = csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cfg_ff <= '0;
      else cfg_ff <= cfg_in;
   end

   pmu_front #(.MAX_PARTICLES(MAX_PARTICLES)) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_command    (req_command),
      .req_slot       (req_slot),
      .req_start_x    (req_start_x),
      .req_start_y    (req_start_y),
      .req_start_z    (req_start_z),
      .req_move_speed (req_move_speed),
      .req_life_limit (req_life_limit),
      .req_time_step  (req_time_step),
      .req_box_min_x  (req_box_min_x),
      .req_box_min_z  (req_box_min_z),
      .req_box_max_x  (req_box_max_x),
      .req_box_max_z  (req_box_max_z),
      .req_push       (push),
      .req_full       (full),
      .cmd            (cmd),
      .cmd_valid      (cmd_valid),
      .cmd_pop        (cmd_pop)
   );

   pmu_engine #(.MAX_PARTICLES(MAX_PARTICLES)) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .rsp       (rsp),
      .rsp_empty (empty),
      .rsp_pop   (pop)
   );

   assign rsp_particle_index = rsp.index;
   assign rsp_pos_x          = rsp.pos_x;
   assign rsp_pos_y          = rsp.pos_y;
   assign rsp_pos_z          = rsp.pos_z;
   assign rsp_life_elapsed   = rsp.life;
   assign rsp_last           = rsp.last;

endmodule

>>> tb/sv/tb_particle_motion_update.sv
// ----------------------------------------------------------------------------
// tb_particle_motion_update: self-checking bench for the particle motion block
// Loads particles, runs spread, drop and diagonal ticks under several register
// settings and checks every particle result against an in-bench fixed-point
// motion model. Both queue sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_particle_motion_update;
   import pmu_pkg::*;

   logic               clock;
   logic               reset;
   logic [1:0]         req_command;
   logic [5:0]         req_slot;
   logic signed [31:0] req_start_x, req_start_y, req_start_z, req_move_speed;
   logic [30:0]        req_life_limit, req_time_step;
   logic signed [31:0] req_box_min_x, req_box_min_z, req_box_max_x, req_box_max_z;
   logic               push, full;
   logic [5:0]         rsp_particle_index;
   logic signed [31:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic [30:0]        rsp_life_elapsed;
   logic               rsp_last, empty, pop;
   logic               csr_valid, csr_ready;
   logic [2:0]         csr_index;
   logic [31:0]        csr_wdata;

   particle_motion_update uut (.*);

   // model state
   logic [31:0] cur_x[64], cur_y[64], cur_z[64], org_x[64], org_y[64], org_z[64];
   logic [31:0] speed_tbl[64];
   logic [30:0] age_tbl[64], limit_tbl[64];
   logic [31:0] pivot_x, pivot_y, pivot_z;
   logic        loop_on;
   logic [6:0]  walk_count;

   rsp_type particle_q[$];
   int          fail_count;
   bit          steady;

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   initial begin
      #20ms;
      $display("status: fail");
      $finish;
   end

   function automatic longint unsigned int_sqrt(input longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic logic [31:0] nudge(input logic [31:0] pos, input longint unsigned m,
                                         input bit neg);
      return neg ? pos - m[31:0] : pos + m[31:0];
   endfunction

   function automatic void spread_step(input int i, input longint unsigned smag, input bit sneg);
      longint d[3];
      longint unsigned m[3], mx, norm, u, dm;
      logic [31:0] p[3];
      p[0] = cur_x[i]; p[1] = cur_y[i]; p[2] = cur_z[i];
      d[0] = longint'($signed(cur_x[i])) - longint'($signed(pivot_x));
      d[1] = longint'($signed(cur_y[i])) - longint'($signed(pivot_y));
      d[2] = longint'($signed(cur_z[i])) - longint'($signed(pivot_z));
      mx = 0;
      for (int k = 0; k < 3; k++) begin
         m[k] = d[k] < 0 ? -d[k] : d[k];
         if (m[k] > mx) mx = m[k];
      end
      if (mx == 0) return;
      while (mx >= 64'h8000_0000) begin
         mx >>= 1;
         for (int k = 0; k < 3; k++) m[k] >>= 1;
      end
      norm = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
      if (norm == 0) return;
      for (int k = 0; k < 3; k++) begin
         u = (m[k] << 16) / norm;
         dm = (u * smag) >> 16;
         p[k] = nudge(p[k], dm, (d[k] < 0) != sneg);
      end
      cur_x[i] = p[0]; cur_y[i] = p[1]; cur_z[i] = p[2];
   endfunction

   function automatic void predict_motion(input cmd_type c);
      int n;
      longint sp;
      longint unsigned smag, age;
      bit sneg;
      rsp_type r;
      if (c.op == CMD_LOAD) begin
         cur_x[c.slot] = c.start_x; org_x[c.slot] = c.start_x;
         cur_y[c.slot] = c.start_y; org_y[c.slot] = c.start_y;
         cur_z[c.slot] = c.start_z; org_z[c.slot] = c.start_z;
         speed_tbl[c.slot] = c.speed;
         age_tbl[c.slot] = '0;
         limit_tbl[c.slot] = c.limit;
         return;
      end
      n = walk_count > 64 ? 64 : walk_count;
      for (int i = 0; i < n; i++) begin
         sp = longint'($signed(speed_tbl[i]));
         sneg = sp < 0;
         smag = ((sneg ? -sp : sp) * longint'(c.dt)) >> 16;
         if (c.op == CMD_SPREAD) begin
            spread_step(i, smag, sneg);
         end else begin
            cur_y[i] = nudge(cur_y[i], smag, !sneg);
            if (c.op == CMD_DIAG) begin
               cur_x[i] = nudge(cur_x[i], smag, !sneg);
               if ($signed(cur_x[i]) < c.box_min_x || $signed(cur_x[i]) > c.box_max_x ||
                   $signed(cur_z[i]) < c.box_min_z || $signed(cur_z[i]) > c.box_max_z)
                  cur_y[i] = cur_y[i] + RISE;
            end
         end
         age = longint'(age_tbl[i]) + longint'(c.dt);
         age_tbl[i] = age > AGE_MAX ? AGE_MAX : age[30:0];
         if (loop_on && age_tbl[i] >= limit_tbl[i]) begin
            age_tbl[i] = '0;
            cur_x[i] = org_x[i]; cur_y[i] = org_y[i]; cur_z[i] = org_z[i];
         end
         r.index = i[5:0];
         r.pos_x = cur_x[i]; r.pos_y = cur_y[i]; r.pos_z = cur_z[i];
         r.life = age_tbl[i];
         r.last = (i + 1 == n);
         particle_q.push_back(r);
      end
   endfunction

   task automatic check_particle();
      rsp_type e;
      if (particle_q.size() == 0) begin
         $display("%0t unexpected result index %0d", $time, rsp_particle_index);
         fail_count++;
         return;
      end
      e = particle_q.pop_front();
      if (rsp_particle_index !== e.index) begin
         $display("%0t index exp %0d act %0d", $time, e.index, rsp_particle_index);
         fail_count++;
      end
      if (rsp_pos_x !== e.pos_x) begin
         $display("%0t pos_x exp %h act %h", $time, e.pos_x, rsp_pos_x);
         fail_count++;
      end
      if (rsp_pos_y !== e.pos_y) begin
         $display("%0t pos_y exp %h act %h", $time, e.pos_y, rsp_pos_y);
         fail_count++;
      end
      if (rsp_pos_z !== e.pos_z) begin
         $display("%0t pos_z exp %h act %h", $time, e.pos_z, rsp_pos_z);
         fail_count++;
      end
      if (rsp_life_elapsed !== e.life) begin
         $display("%0t life exp %h act %h", $time, e.life, rsp_life_elapsed);
         fail_count++;
      end
      if (rsp_last !== e.last) begin
         $display("%0t last exp %b act %b", $time, e.last, rsp_last);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) check_particle();
         pop <= steady || ($urandom_range(99) >= 25);
      end
   end

   task automatic send_cmd(input cmd_type c);
      if (!steady) begin
         while ($urandom_range(99) < 25) begin
            push <= 1'b0;
            @(posedge clock);
         end
      end
      req_command <= c.op;       req_slot <= c.slot;
      req_start_x <= c.start_x;  req_start_y <= c.start_y;  req_start_z <= c.start_z;
      req_move_speed <= c.speed; req_life_limit <= c.limit; req_time_step <= c.dt;
      req_box_min_x <= c.box_min_x; req_box_min_z <= c.box_min_z;
      req_box_max_x <= c.box_max_x; req_box_max_z <= c.box_max_z;
      push <= 1'b1;
      do @(posedge clock); while (full);
      predict_motion(c);
   endtask

   task automatic drain();
      push <= 1'b0;
      while (particle_q.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_PIVOT_X: pivot_x = data;
         CSR_PIVOT_Y: pivot_y = data;
         CSR_PIVOT_Z: pivot_z = data;
         CSR_LOOP_EN: loop_on = data[0];
         CSR_IN_USE:  walk_count = data[6:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick32();
      case ($urandom_range(7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2, 3: return $urandom;
         default: return $urandom_range(32'h00C8_0000) - 32'h0064_0000;
      endcase
   endfunction

   function automatic cmd_type noise_cmd();
      cmd_type c;
      c.op = cmd_code_type'($urandom_range(3));
      c.slot = 6'($urandom_range(63));
      c.start_x = pick32(); c.start_y = pick32(); c.start_z = pick32();
      c.speed = pick32();
      c.limit = $urandom_range(3) == 0 ? 31'($urandom) : 31'($urandom_range(32'h0008_0000));
      c.dt = $urandom_range(7) == 0 ? 31'($urandom) : 31'($urandom_range(32'h0002_0000));
      c.box_min_x = -$signed(32'($urandom_range(32'h0064_0000)));
      c.box_min_z = -$signed(32'($urandom_range(32'h0064_0000)));
      c.box_max_x = $urandom_range(32'h0064_0000);
      c.box_max_z = $urandom_range(32'h0064_0000);
      if ($urandom_range(9) == 0) begin
         c.box_min_x = pick32(); c.box_max_x = pick32();
         c.box_min_z = pick32(); c.box_max_z = pick32();
      end
      return c;
   endfunction

   function automatic cmd_type load_cmd(input int slot, input logic [31:0] x, y, z, speed,
                                        input logic [30:0] limit);
      cmd_type c;
      c = noise_cmd();
      c.op = CMD_LOAD; c.slot = 6'(slot);
      c.start_x = x; c.start_y = y; c.start_z = z; c.speed = speed; c.limit = limit;
      return c;
   endfunction

   function automatic cmd_type tick_cmd(input cmd_code_type op, input logic [30:0] dt);
      cmd_type c;
      c = noise_cmd();
      c.op = op;
      c.dt = dt;
      return c;
   endfunction

   // extremes of position and speed, drop and diagonal ticks, tick with nothing in use
   task automatic test_drop_diag();
      csr_write(CSR_IN_USE, 0);
      send_cmd(load_cmd(0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h7FFF_FFFF, 31'h7FFF_FFFF));
      send_cmd(load_cmd(1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0010_0000, 32'h8000_0000, 0));
      send_cmd(load_cmd(2, 0, 0, 32'h8000_0000, 32'h0001_0000, 31'h0004_0000));
      send_cmd(load_cmd(3, 32'h0005_0000, 32'h0005_0000, 32'h0005_0000, 32'hFFFF_0000,
                        31'h0001_0000));
      send_cmd(tick_cmd(CMD_DROP, 31'h0001_0000));
      drain();
      csr_write(CSR_IN_USE, 4);
      send_cmd(tick_cmd(CMD_DROP, 31'h0001_0000));
      send_cmd(tick_cmd(CMD_DIAG, 31'h0000_8000));
      send_cmd(tick_cmd(CMD_DIAG, 31'h7FFF_FFFF));
      send_cmd(tick_cmd(CMD_DROP, 0));
      drain();
   endtask

   // spread from a mid-range pivot and from extreme pivots
   task automatic test_spread();
      csr_write(CSR_PIVOT_X, 32'h0005_0000);
      csr_write(CSR_PIVOT_Y, 32'h0005_0000);
      csr_write(CSR_PIVOT_Z, 32'h0005_0000);
      send_cmd(tick_cmd(CMD_SPREAD, 31'h0001_0000));
      drain();
      csr_write(CSR_PIVOT_X, 32'h8000_0000);
      csr_write(CSR_PIVOT_Y, 32'h7FFF_FFFF);
      csr_write(CSR_PIVOT_Z, 32'h8000_0000);
      send_cmd(tick_cmd(CMD_SPREAD, 31'h0002_0000));
      send_cmd(tick_cmd(CMD_SPREAD, 31'h7FFF_FFFF));
      drain();
   endtask

   // looping on: zero limit respawns every tick, saturated age reaches the limit
   task automatic test_respawn();
      csr_write(CSR_LOOP_EN, 1);
      send_cmd(tick_cmd(CMD_DROP, 31'h0002_0000));
      send_cmd(tick_cmd(CMD_DIAG, 31'h0002_0000));
      send_cmd(tick_cmd(CMD_SPREAD, 31'h7FFF_FFFF));
      send_cmd(tick_cmd(CMD_DROP, 31'h7FFF_FFFF));
      drain();
      csr_write(csr_index_type'(3'd7), $urandom);
   endtask

   task automatic test_random();
      cmd_type c;
      int span;
      steady = 1'b1;
      for (int s = 0; s < 64; s++) send_cmd(load_cmd(s, pick32(), pick32(), pick32(), pick32(),
                                                     31'($urandom_range(32'h0008_0000))));
      drain();
      steady = 1'b0;
      for (int phase = 0; phase < 10; phase++) begin
         steady = (phase == 3);
         csr_write(CSR_PIVOT_X, pick32());
         csr_write(CSR_PIVOT_Y, pick32());
         csr_write(CSR_PIVOT_Z, pick32());
         csr_write(CSR_LOOP_EN, $urandom_range(1));
         case (phase)
            3: span = 64;
            7: span = 127;
            5: span = 0;
            default: span = $urandom_range(1, 8);
         endcase
         csr_write(CSR_IN_USE, span);
         for (int k = 0; k < (span > 8 ? 10 : 30); k++) begin
            c = noise_cmd();
            if ($urandom_range(1)) c.op = CMD_LOAD;
            send_cmd(c);
         end
         drain();
      end
      steady = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      push = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_command = '0; req_slot = '0;
      req_start_x = '0; req_start_y = '0; req_start_z = '0;
      req_move_speed = '0; req_life_limit = '0; req_time_step = '0;
      req_box_min_x = '0; req_box_min_z = '0; req_box_max_x = '0; req_box_max_z = '0;
      fail_count = 0;
      steady = 1'b0;
      pivot_x = '0; pivot_y = '0; pivot_z = '0;
      loop_on = 1'b0;
      walk_count = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_drop_diag();
      test_spread();
      test_respawn();
      test_random();
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

>>> sim.f
rtl/pmu_pkg.sv
rtl/pmu_fifo.sv
rtl/pmu_front.sv
rtl/pmu_isqrt.sv
rtl/pmu_div.sv
rtl/pmu_engine.sv
rtl/particle_motion_update.sv
tb/sv/tb_particle_motion_update.sv
